/* src/encoder_period_speed_meter_top_assert.svh */
// assertion macros for the encoder period speed meter checker
`ifndef ENCODER_PERIOD_SPEED_METER_TOP_ASSERT_SVH
`define ENCODER_PERIOD_SPEED_METER_TOP_ASSERT_SVH

// clocked assertion, disabled while reset is held low
`define EPSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define EPSM_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/epsm_pkg.sv */
// shared constants and types of the encoder period speed meter
package epsm_pkg;

    localparam int WHEELS_DEF = 4;
    localparam int WHEEL_W    = 2;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 16;
    localparam int NUM_W      = 24;
    localparam int SPEED_W    = 22;

    localparam int IN_DATA_W  = 24;  // wheel, timer_count, zero pad
    localparam int OUT_DATA_W = 40;  // speed, filtered period, zero pad

    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0]   NUM_RESET = 24'd3926991;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 22'h3F_FFFF;

    // modes one and three are speed queries
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

/* src/epsm_ctrl.sv */
// controller state machine of the encoder period speed meter
module epsm_ctrl
    import epsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_UPD:  o_cmd.update = 1'b1;
            S_LOAD: o_cmd.load   = 1'b1;
            S_DIV:  o_cmd.step   = 1'b1;
            S_FIN:  o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* src/epsm_dpath.sv */
// datapath: per-wheel period state, period filter, restoring divider, result register
module epsm_dpath
    import epsm_pkg::*;
#(
    parameter int WHEELS = WHEELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [NUM_W-1:0]      i_cfg_wdata,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [WHEEL_W-1:0]    i_wheel,
    input  logic [CNT_W-1:0]      i_timer_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SPEED_W-1:0]    o_speed,
    output logic [CNT_W-1:0]      o_filtered_period,
    output logic                  o_zero_period
);

    localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [NUM_W-1:0]   r_num;
    logic [MODE_W-1:0]  r_mode;
    logic [WHEEL_W-1:0] r_wheel;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_phase [WHEELS];
    logic [CNT_W-1:0]   r_start [WHEELS];
    logic [CNT_W-1:0]   r_filt  [WHEELS];

    logic [CNT_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;

    logic               r_out_valid;
    logic [SPEED_W-1:0] r_speed;
    logic [CNT_W-1:0]   r_period;
    logic               r_zero;

    logic [WIDX-1:0]    idx;
    logic               wheel_ok;
    logic [CNT_W-1:0]   per;
    logic [CNT_W:0]     sum;
    logic [CNT_W:0]     rem_sh;
    logic [CNT_W+1:0]   diff;

    assign idx      = WIDX'(r_wheel);
    assign wheel_ok = ({30'd0, r_wheel} < 32'(WHEELS));
    assign per      = r_cnt - r_start[idx];
    assign sum      = {1'b0, r_filt[idx]} + {1'b0, per};

    // one quotient bit per step
    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_RESET;
        end else if (i_cfg_we) begin
            r_num <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_wheel <= i_wheel;
            r_cnt   <= i_timer_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_phase[i] <= 1'b0;
                r_start[i] <= '0;
                r_filt[i]  <= '0;
            end
        end else if (i_cmd.update) begin
            if (r_mode == MODE_ZERO) begin
                for (int i = 0; i < WHEELS; i++) begin
                    r_filt[i] <= '0;
                end
            end else if (r_mode == MODE_EDGE && wheel_ok) begin
                if (!r_phase[idx]) begin
                    r_start[idx] <= r_cnt;
                    r_phase[idx] <= 1'b1;
                end else begin
                    r_filt[idx]  <= sum[CNT_W:1];
                    r_phase[idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den  <= wheel_ok ? r_filt[idx] : '0;
            r_rem  <= '0;
            r_quo  <= r_num;
            r_step <= '0;
        end else if (i_cmd.step) begin
            if (!diff[CNT_W+1]) begin
                r_rem <= diff[CNT_W-1:0];
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
            end
            r_quo  <= {r_quo[NUM_W-2:0], ~diff[CNT_W+1]};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (!wheel_ok) begin
                r_speed  <= '0;
                r_period <= '0;
                r_zero   <= 1'b0;
            end else if (r_den == '0) begin
                r_speed  <= SPEED_MAX;
                r_period <= '0;
                r_zero   <= 1'b1;
            end else begin
                // quotient overflow saturates without the zero flag
                r_speed  <= (r_quo > NUM_W'(SPEED_MAX)) ? SPEED_MAX : r_quo[SPEED_W-1:0];
                r_period <= r_den;
                r_zero   <= 1'b0;
            end
        end
    end

    assign o_status.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_speed           = r_speed;
    assign o_filtered_period = r_period;
    assign o_zero_period     = r_zero;

endmodule

/* src/encoder_period_speed_meter_top.sv */
// an accepted word passes the update, load, divide and finish states before its result is valid
// the next word is taken after the finish state, which holds while a result waits to be taken
// the 24-step restoring divider (one quotient bit a cycle) takes most of the time per word
// a new word is taken while the previous result still sits in the output register
// reset: synchronous, active low; clears all wheel state and loads the default numerator
module encoder_period_speed_meter_top
    import epsm_pkg::*;
#(
    parameter int WHEELS = WHEELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [NUM_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // wheel[1:0], timer_count[17:2], zero pad
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // speed[21:0], filtered_period[37:22], zero pad
    output logic [0:0]            m_axis_tuser    // zero_period[0]
);

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [SPEED_W-1:0] speed;
    logic [CNT_W-1:0]   period;
    logic               zero_period;

    epsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    epsm_dpath #(
        .WHEELS (WHEELS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (s_axis_tuser),
        .i_wheel           (s_axis_tdata[WHEEL_W-1:0]),
        .i_timer_count     (s_axis_tdata[WHEEL_W+CNT_W-1:WHEEL_W]),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_speed           (speed),
        .o_filtered_period (period),
        .o_zero_period     (zero_period)
    );

    assign m_axis_tdata = {(OUT_DATA_W - SPEED_W - CNT_W)'(0), period, speed};
    assign m_axis_tuser = zero_period;

endmodule

/* src/epsm_checker.sv */
// port-level assertions of the encoder period speed meter, bound to the top level
`include "encoder_period_speed_meter_top_assert.svh"

module epsm_checker
    import epsm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]            m_axis_tuser
);

    // zero flag only with a saturated speed and a zero period
    `EPSM_ASSERT(a_zero_sat, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[SPEED_W-1:0] == SPEED_MAX && m_axis_tdata[SPEED_W+CNT_W-1:SPEED_W] == '0, "zero flag without saturated speed")

    `EPSM_ASSERT(a_per_flag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[SPEED_W+CNT_W-1:SPEED_W] != '0 |-> !m_axis_tuser[0], "zero flag with nonzero period")

    // one word in flight: no second accept straight after the first
    `EPSM_ASSERT(a_one_word, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "word accepted while busy")

    `EPSM_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `EPSM_ASSERT_NORST(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind encoder_period_speed_meter_top epsm_checker u_epsm_checker (.*);

/* dv/encoder_period_speed_meter_checker.sv */
// wheel speed predictor and result checker for the encoder period speed meter
`timescale 1ns / 1ps

module encoder_period_speed_meter_checker
    import epsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [NUM_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    input  logic [IN_DATA_W-1:0]  i_in_tdata,    // wheel[1:0], timer_count[17:2], zero pad
    input  logic [MODE_W-1:0]     i_in_tuser,    // mode[1:0]
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    input  logic [OUT_DATA_W-1:0] i_out_tdata,   // speed[21:0], filtered_period[37:22], zero pad
    input  logic [0:0]            i_out_tuser,   // zero_period[0]
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [CNT_W-1:0]   period;
        logic               zero_period;
    } t_wheel_report;

    t_wheel_report      pending_reports[$];
    logic               awaiting_end [WHEELS_DEF];
    logic [CNT_W-1:0]   start_stamp  [WHEELS_DEF];
    logic [CNT_W-1:0]   avg_period   [WHEELS_DEF];
    logic [NUM_W-1:0]   numerator;
    int                 fail_total;

    function automatic t_wheel_report wheel_report(input logic [WHEEL_W-1:0] wheel);
        t_wheel_report   rep;
        logic [NUM_W-1:0] quot;
        rep.period = avg_period[wheel];
        if (avg_period[wheel] == '0) begin
            rep.speed       = SPEED_MAX;
            rep.zero_period = 1'b1;
        end else begin
            quot            = numerator / avg_period[wheel];
            rep.speed       = (quot > SPEED_MAX) ? SPEED_MAX : quot[SPEED_W-1:0];
            rep.zero_period = 1'b0;
        end
        return rep;
    endfunction

    // fold one accepted word into the wheel state and return the report it causes
    function automatic t_wheel_report apply_word(input logic [MODE_W-1:0] mode,
                                                 input logic [WHEEL_W-1:0] wheel,
                                                 input logic [CNT_W-1:0] stamp);
        logic [CNT_W-1:0] lap;
        logic [CNT_W:0]   sum;
        if (mode == MODE_EDGE) begin
            if (!awaiting_end[wheel]) begin
                start_stamp[wheel]  = stamp;
                awaiting_end[wheel] = 1'b1;
            end else begin
                lap                 = stamp - start_stamp[wheel];
                sum                 = {1'b0, avg_period[wheel]} + {1'b0, lap};
                avg_period[wheel]   = sum[CNT_W:1];
                awaiting_end[wheel] = 1'b0;
            end
        end else if (mode == MODE_ZERO) begin
            for (int i = 0; i < WHEELS_DEF; i++) avg_period[i] = '0;
        end
        return wheel_report(wheel);
    endfunction

    always @(posedge i_clk) begin
        t_wheel_report seen;
        t_wheel_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < WHEELS_DEF; i++) begin
                awaiting_end[i] = 1'b0;
                start_stamp[i]  = '0;
                avg_period[i]   = '0;
            end
            numerator  = NUM_RESET;
            fail_total = 0;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) numerator = i_cfg_wdata;
            if (i_in_tvalid && i_in_tready) begin
                pending_reports.push_back(apply_word(i_in_tuser, i_in_tdata[WHEEL_W-1:0],
                                                     i_in_tdata[WHEEL_W +: CNT_W]));
            end
            if (i_out_tvalid && i_out_tready) begin
                seen.speed       = i_out_tdata[SPEED_W-1:0];
                seen.period      = i_out_tdata[SPEED_W +: CNT_W];
                seen.zero_period = i_out_tuser[0];
                if (pending_reports.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result word with nothing outstanding: speed %0d period %0d zero %0d",
                                 $realtime, seen.speed, seen.period, seen.zero_period);
                    fail_total++;
                end else begin
                    want = pending_reports.pop_front();
                    if (seen !== want) begin
                        if (fail_total < 10)
                            $display("%0t: mismatch: speed %0d/%0d period %0d/%0d zero %0d/%0d (exp/act)",
                                     $realtime, want.speed, seen.speed, want.period, seen.period,
                                     want.zero_period, seen.zero_period);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_reports.size();
    end

endmodule

/* dv/tb_encoder_period_speed_meter_top.sv */
// stimulus, back-pressure and verdict for the encoder period speed meter
`timescale 1ns / 1ps

module tb_encoder_period_speed_meter_top;
    import epsm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused code, behaves as a query
    localparam int                PHASE_WORDS = 255;
    localparam int                HOLD_CYCLES = 300;
    localparam int                STALL_LIMIT = 4000;
    localparam int                TAIL_CYCLES = 40;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [NUM_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int               fail_count;
    int               outstanding;
    int               stall_cycles   = 0;
    int               words_sent     = 0;
    int               results_taken  = 0;
    int               settings_used  = 1;
    int               holds_asked    = 0;
    int               holds_done     = 0;
    bit               sink_idling    = 1'b1;
    logic [CNT_W-1:0] wheel_stamp [WHEELS_DEF];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    encoder_period_speed_meter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    encoder_period_speed_meter_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (outstanding)
    );

    // watchdog: any accepted word on either side restarts the count
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) results_taken <= results_taken + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: long hold-offs on request, otherwise random stalls while sink_idling is set
    initial begin : result_sink
        @(posedge i_clk);
        forever begin
            if (holds_done < holds_asked) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else if (sink_idling && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [WHEEL_W-1:0] wheel,
                             input logic [CNT_W-1:0] stamp, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - CNT_W - WHEEL_W){1'b0}}, stamp, wheel};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_numerator(input logic [NUM_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // mostly short periods so that large numerators push the quotient past full scale
    function automatic logic [CNT_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return CNT_W'($urandom_range(0, 31));
        if (roll < 70) return CNT_W'($urandom_range(100, 5000));
        if (roll < 90) return CNT_W'($urandom);
        return CNT_W'($urandom_range(65500, 65535));
    endfunction

    task automatic run_phase(input int n_words, input bit idling, input bit with_hold);
        int               roll;
        logic [WHEEL_W-1:0] wheel;
        for (int k = 0; k < n_words; k++) begin
            roll  = $urandom_range(0, 99);
            wheel = WHEEL_W'($urandom_range(0, WHEELS_DEF - 1));
            if (with_hold && k == 100) holds_asked++;
            if (roll < 68) begin
                wheel_stamp[wheel] = wheel_stamp[wheel] + pick_period();
                send_word(MODE_EDGE, wheel, wheel_stamp[wheel], idling && (k % 100) >= 30);
            end else if (roll < 88) begin
                send_word(MODE_QUERY, wheel, CNT_W'($urandom), idling && (k % 100) >= 30);
            end else if (roll < 93) begin
                send_word(MODE_SPARE, wheel, CNT_W'($urandom), idling && (k % 100) >= 30);
            end else if (roll < 96) begin
                send_word(MODE_ZERO, wheel, CNT_W'($urandom), idling && (k % 100) >= 30);
            end else begin
                // stray edge with an unrelated timer value
                send_word(MODE_EDGE, wheel, CNT_W'($urandom), idling && (k % 100) >= 30);
            end
        end
    endtask

    initial begin : stimulus
        logic [NUM_W-1:0] settings [6];
        for (int i = 0; i < WHEELS_DEF; i++) wheel_stamp[i] = CNT_W'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, timer extremes, wrap, zero period, every mode
        send_word(MODE_QUERY, 2'd0, 16'h0000, 1'b0);
        send_word(MODE_SPARE, 2'd3, 16'hFFFF, 1'b0);
        send_word(MODE_EDGE,  2'd0, 16'h0000, 1'b0);
        send_word(MODE_EDGE,  2'd0, 16'hFFFF, 1'b0);
        send_word(MODE_EDGE,  2'd1, 16'hFFFF, 1'b0);
        send_word(MODE_EDGE,  2'd1, 16'h0002, 1'b0);   // timer wrap
        send_word(MODE_QUERY, 2'd1, 16'h5A5A, 1'b0);
        send_word(MODE_EDGE,  2'd2, 16'h5555, 1'b0);
        send_word(MODE_EDGE,  2'd2, 16'hAAAA, 1'b0);
        send_word(MODE_EDGE,  2'd3, 16'd100,  1'b0);
        send_word(MODE_EDGE,  2'd3, 16'd100,  1'b0);   // zero-length period
        send_word(MODE_QUERY, 2'd3, 16'h0000, 1'b0);
        send_word(MODE_EDGE,  2'd0, 16'd1000, 1'b0);
        send_word(MODE_EDGE,  2'd0, 16'd999,  1'b0);
        send_word(MODE_ZERO,  2'd2, 16'hFFFF, 1'b0);
        send_word(MODE_QUERY, 2'd0, 16'h0000, 1'b0);
        send_word(MODE_EDGE,  2'd0, 16'd7,    1'b0);
        send_word(MODE_EDGE,  2'd0, 16'd9,    1'b0);
        send_word(MODE_EDGE,  2'd1, 16'd0,    1'b0);
        send_word(MODE_EDGE,  2'd1, 16'd4,    1'b0);
        drain_results();

        // full-scale numerator over a one-tick period overflows the speed
        write_numerator('1);
        send_word(MODE_QUERY, 2'd0, 16'h0000, 1'b0);
        send_word(MODE_SPARE, 2'd1, 16'h0000, 1'b0);
        send_word(MODE_QUERY, 2'd2, 16'h0000, 1'b0);
        drain_results();

        settings[0] = NUM_RESET;
        settings[1] = '1;
        settings[2] = '0;
        settings[3] = NUM_W'(1);
        settings[4] = NUM_W'($urandom_range(1, 24'hFF_FFFF));
        settings[5] = NUM_W'($urandom_range(2, 65535));
        for (int p = 0; p < 6; p++) begin
            write_numerator(settings[p]);
            sink_idling = (p != 5);
            run_phase(PHASE_WORDS, p != 5, p == 1);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d words and %0d results over %0d numerator settings",
                 words_sent, results_taken, settings_used);
        $display("incl. zero, one and full-scale numerators, a long output hold and drained pauses");
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
